### rtl/bxds_pkg.sv
// Shared types and constants for the box average downscaler.
// No dependencies; imported by every module of the block except bxds_ram.
package bxds_pkg;

    localparam int PIX_W        = 8;
    localparam int QUOT_W       = 8;
    localparam int SF_W         = 5;
    localparam int DIM_W        = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int HEIGHT_LIMIT = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [SF_W-1:0]  SCALE_RESET  = 5'd1;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd1024;

    typedef struct packed {
        logic wr;
        logic first;
        logic emit;
        logic row_end;
        logic frame_end;
    } blk_flags_t;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } end_flags_t;

endpackage

### rtl/bxds_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bxds_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bxds_raster.sv
// Configuration registers and raster position counters; derives the block
// position flags and accumulator address for the next pixel. Uses bxds_pkg.
module bxds_raster import bxds_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 16,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int FW = $clog2(MAX_FACTOR + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    output logic [FW-1:0]         f,
    output logic [AW-1:0]         addr,
    output blk_flags_t            flags
);

    localparam int SFX_W = 8;
    localparam int WX_W  = 14;
    localparam int CX_W  = WW + 2;
    localparam int RX_W  = DIM_W + 2;

    logic [SF_W-1:0]  sf_reg, sf_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [WW-1:0]    col_cnt_reg, col_cnt_next;
    logic [DIM_W-1:0] row_cnt_reg, row_cnt_next;
    logic [FW-1:0]    cib_reg, cib_next;
    logic [FW-1:0]    rib_reg, rib_next;
    logic [AW-1:0]    col_addr_reg, col_addr_next;
    logic [WW-1:0]    col_base_reg, col_base_next;
    logic [DIM_W-1:0] row_base_reg, row_base_next;

    logic [SFX_W-1:0] sf_x, f_x;
    logic [WX_W-1:0]  w_x, wc_x;
    logic [WW-1:0]    w;
    logic [DIM_W-1:0] h;
    logic [WW-1:0]    col_cnt_inc;
    logic [DIM_W-1:0] row_cnt_inc;
    logic [FW-1:0]    cib_inc, rib_inc;
    logic             col_fit, row_fit, col_last, row_last, cib_last, rib_last;
    logic             restart;

    // clamp the registers to their usable ranges
    always_comb
    begin
        sf_x = SFX_W'(sf_reg);
        if (sf_x == '0)
            f_x = SFX_W'(1);
        else if (sf_x > SFX_W'(MAX_FACTOR))
            f_x = SFX_W'(MAX_FACTOR);
        else
            f_x = sf_x;

        w_x = WX_W'(width_reg);
        if (w_x == '0)
            wc_x = WX_W'(1);
        else if (w_x > WX_W'(MAX_WIDTH))
            wc_x = WX_W'(MAX_WIDTH);
        else
            wc_x = w_x;

        if (height_reg == '0)
            h = DIM_W'(1);
        else if (height_reg > DIM_W'(HEIGHT_LIMIT))
            h = DIM_W'(HEIGHT_LIMIT);
        else
            h = height_reg;
    end

    assign f = FW'(f_x);
    assign w = WW'(wc_x);

    assign col_fit  = (CX_W'(col_base_reg) + CX_W'(f)) <= CX_W'(w);
    assign col_last = (CX_W'(col_base_reg) + CX_W'(f) + CX_W'(f)) > CX_W'(w);
    assign row_fit  = (RX_W'(row_base_reg) + RX_W'(f)) <= RX_W'(h);
    assign row_last = (RX_W'(row_base_reg) + RX_W'(f) + RX_W'(f)) > RX_W'(h);
    assign cib_last = cib_reg == (f - FW'(1));
    assign rib_last = rib_reg == (f - FW'(1));

    assign addr            = col_addr_reg;
    assign flags.wr        = col_fit && row_fit;
    assign flags.first     = (cib_reg == '0) && (rib_reg == '0);
    assign flags.emit      = col_fit && row_fit && cib_last && rib_last;
    assign flags.row_end   = col_last;
    assign flags.frame_end = col_last && row_last;

    assign col_cnt_inc = col_cnt_reg + WW'(1);
    assign row_cnt_inc = row_cnt_reg + DIM_W'(1);
    assign cib_inc     = cib_reg + FW'(1);
    assign rib_inc     = rib_reg + FW'(1);

    always_comb
    begin
        sf_next       = sf_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        col_cnt_next  = col_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        cib_next      = cib_reg;
        rib_next      = rib_reg;
        col_addr_next = col_addr_reg;
        col_base_next = col_base_reg;
        row_base_next = row_base_reg;
        restart       = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_SCALE_FACTOR:
                begin
                    sf_next = cfg_data[SF_W-1:0];
                    restart = 1'b1;
                end
                CFG_IMAGE_WIDTH:
                begin
                    width_next = cfg_data;
                    restart    = 1'b1;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_data;
                    restart     = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
        else if (accept)
        begin
            col_cnt_next = col_cnt_inc;
            cib_next     = cib_inc;
            if (cib_inc >= f)
            begin
                cib_next      = '0;
                col_addr_next = col_addr_reg + AW'(1);
                col_base_next = col_base_reg + WW'(f);
            end
            if (col_cnt_inc >= w)
            begin
                col_cnt_next  = '0;
                cib_next      = '0;
                col_addr_next = '0;
                col_base_next = '0;
                row_cnt_next  = row_cnt_inc;
                rib_next      = rib_inc;
                if (rib_inc >= f)
                begin
                    rib_next      = '0;
                    row_base_next = row_base_reg + DIM_W'(f);
                end
                if (row_cnt_inc >= h)
                begin
                    restart = 1'b1;
                end
            end
        end

        if (restart)
        begin
            col_cnt_next  = '0;
            row_cnt_next  = '0;
            cib_next      = '0;
            rib_next      = '0;
            col_addr_next = '0;
            col_base_next = '0;
            row_base_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_reg       <= SCALE_RESET;
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            cib_reg      <= '0;
            rib_reg      <= '0;
            col_addr_reg <= '0;
            col_base_reg <= '0;
            row_base_reg <= '0;
        end
        else
        begin
            sf_reg       <= sf_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            cib_reg      <= cib_next;
            rib_reg      <= rib_next;
            col_addr_reg <= col_addr_next;
            col_base_reg <= col_base_next;
            row_base_reg <= row_base_next;
        end
    end

endmodule

### rtl/bxds_accum.sv
// Column accumulator: read-modify-write of the block sums held in a RAM,
// with forwarding of the last write. Uses bxds_pkg and bxds_ram.
module bxds_accum import bxds_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 16,
    localparam int AW    = $clog2(MAX_WIDTH),
    localparam int FW    = $clog2(MAX_FACTOR + 1),
    localparam int SUM_W = PIX_W + 2 * FW
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [AW-1:0]    addr,
    input  blk_flags_t       flags,
    input  logic [PIX_W-1:0] pixel_red,
    input  logic [PIX_W-1:0] pixel_green,
    input  logic [PIX_W-1:0] pixel_blue,
    output logic             launch,
    output logic [SUM_W-1:0] sum_red,
    output logic [SUM_W-1:0] sum_green,
    output logic [SUM_W-1:0] sum_blue,
    output end_flags_t       launch_flags
);

    localparam int MEM_W = 3 * SUM_W;

    logic             s1_valid_reg;
    logic             s1_first_reg;
    logic             s1_emit_reg;
    end_flags_t       s1_end_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic [PIX_W-1:0] s1_red_reg, s1_green_reg, s1_blue_reg;
    logic             fwd_valid_reg;
    logic [AW-1:0]    fwd_addr_reg;
    logic [MEM_W-1:0] fwd_sum_reg;

    logic [MEM_W-1:0] rdata, base, wdata;
    logic [SUM_W-1:0] base_red, base_green, base_blue;

    bxds_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_WIDTH)
    ) u_sums (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (wdata),
        .raddr (addr),
        .rdata (rdata)
    );

    // take the previous write when it hit the same column
    assign base = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_sum_reg : rdata;
    assign base_red   = base[3*SUM_W-1:2*SUM_W];
    assign base_green = base[2*SUM_W-1:SUM_W];
    assign base_blue  = base[SUM_W-1:0];

    always_comb
    begin
        if (s1_first_reg)
        begin
            sum_red   = SUM_W'(s1_red_reg);
            sum_green = SUM_W'(s1_green_reg);
            sum_blue  = SUM_W'(s1_blue_reg);
        end
        else
        begin
            sum_red   = base_red + SUM_W'(s1_red_reg);
            sum_green = base_green + SUM_W'(s1_green_reg);
            sum_blue  = base_blue + SUM_W'(s1_blue_reg);
        end
    end

    assign wdata        = {sum_red, sum_green, sum_blue};
    assign launch       = s1_valid_reg && s1_emit_reg;
    assign launch_flags = s1_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept && flags.wr;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_first_reg       <= flags.first;
            s1_emit_reg        <= flags.emit;
            s1_end_reg.row_end   <= flags.row_end;
            s1_end_reg.frame_end <= flags.frame_end;
            s1_addr_reg        <= addr;
            s1_red_reg         <= pixel_red;
            s1_green_reg       <= pixel_green;
            s1_blue_reg        <= pixel_blue;
        end
        fwd_addr_reg <= s1_addr_reg;
        fwd_sum_reg  <= wdata;
    end

endmodule

### rtl/bxds_divider.sv
// Bit-serial divider for the three block sums by the block area, followed by
// the output register. Uses bxds_pkg.
module bxds_divider import bxds_pkg::*; #(
    parameter int MAX_FACTOR = 16,
    localparam int FW    = $clog2(MAX_FACTOR + 1),
    localparam int SUM_W = PIX_W + 2 * FW
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [FW-1:0]     f,
    input  logic              launch,
    input  logic [SUM_W-1:0]  sum_red,
    input  logic [SUM_W-1:0]  sum_green,
    input  logic [SUM_W-1:0]  sum_blue,
    input  end_flags_t        launch_flags,
    output logic              busy,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [QUOT_W-1:0] avg_red,
    output logic [QUOT_W-1:0] avg_green,
    output logic [QUOT_W-1:0] avg_blue,
    output logic              row_end,
    output logic              frame_end
);

    localparam int AREA_W = 2 * FW;
    localparam int STEP_W = $clog2(QUOT_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  rem_reg [3];
    logic [SUM_W-1:0]  rem_next [3];
    logic [QUOT_W-1:0] q_reg [3];
    logic [QUOT_W-1:0] q_next [3];
    logic [SUM_W-1:0]  d_reg, d_next;
    end_flags_t        end_reg, end_next;
    logic              out_valid_reg, out_valid_next;
    logic [QUOT_W-1:0] avg_red_reg, avg_green_reg, avg_blue_reg;
    logic              row_end_reg, frame_end_reg;
    logic [AREA_W-1:0] area;
    logic              load;

    assign area = AREA_W'(f) * AREA_W'(f);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        d_next     = d_reg;
        end_next   = end_reg;
        load       = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            rem_next[i] = rem_reg[i];
            q_next[i]   = q_reg[i];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (launch)
                begin
                    rem_next[0] = sum_red;
                    rem_next[1] = sum_green;
                    rem_next[2] = sum_blue;
                    for (int i = 0; i < 3; i++)
                    begin
                        q_next[i] = '0;
                    end
                    d_next     = SUM_W'(area) << (QUOT_W - 1);
                    step_next  = '0;
                    end_next   = launch_flags;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // one quotient bit per cycle, all channels together
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[i] >= d_reg)
                    begin
                        rem_next[i] = rem_reg[i] - d_reg;
                        q_next[i]   = {q_reg[i][QUOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q_next[i] = {q_reg[i][QUOT_W-2:0], 1'b0};
                    end
                end
                d_next    = d_reg >> 1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(QUOT_W - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        d_reg    <= d_next;
        end_reg  <= end_next;
        for (int i = 0; i < 3; i++)
        begin
            rem_reg[i] <= rem_next[i];
            q_reg[i]   <= q_next[i];
        end
        if (load)
        begin
            avg_red_reg   <= q_reg[0];
            avg_green_reg <= q_reg[1];
            avg_blue_reg  <= q_reg[2];
            row_end_reg   <= end_reg.row_end;
            frame_end_reg <= end_reg.frame_end;
        end
    end

    assign busy      = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign avg_red   = avg_red_reg;
    assign avg_green = avg_green_reg;
    assign avg_blue  = avg_blue_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

### rtl/box_average_downscale.sv
// Box average downscaler. One pixel per cycle; the pixel that completes a block
// is held off while the divider still holds the previous block's average.
// Divider: one quotient bit per cycle, then output register.
// Reset: asynchronous, clears counters, handshake state and registers to defaults;
// the sums RAM has no reset, each entry is written at a block's first pixel.
module box_average_downscale import bxds_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel_red,
    input  logic [PIX_W-1:0]      pixel_green,
    input  logic [PIX_W-1:0]      pixel_blue,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [QUOT_W-1:0]     avg_red,
    output logic [QUOT_W-1:0]     avg_green,
    output logic [QUOT_W-1:0]     avg_blue,
    output logic                  row_end,
    output logic                  frame_end
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int SUM_W = PIX_W + 2 * FW;

    logic             accept;
    logic [FW-1:0]    f;
    logic [AW-1:0]    addr;
    blk_flags_t       flags;
    logic             launch;
    logic [SUM_W-1:0] sum_red, sum_green, sum_blue;
    end_flags_t       launch_flags;
    logic             div_busy;

    // hold a block-completing pixel until the divider is free
    assign in_stall = flags.emit && (div_busy || launch);
    assign accept   = in_valid && !in_stall;

    bxds_raster #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_raster (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .f         (f),
        .addr      (addr),
        .flags     (flags)
    );

    bxds_accum #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .addr         (addr),
        .flags        (flags),
        .pixel_red    (pixel_red),
        .pixel_green  (pixel_green),
        .pixel_blue   (pixel_blue),
        .launch       (launch),
        .sum_red      (sum_red),
        .sum_green    (sum_green),
        .sum_blue     (sum_blue),
        .launch_flags (launch_flags)
    );

    bxds_divider #(
        .MAX_FACTOR (MAX_FACTOR)
    ) u_divider (
        .clk          (clk),
        .rst_n        (rst_n),
        .f            (f),
        .launch       (launch),
        .sum_red      (sum_red),
        .sum_green    (sum_green),
        .sum_blue     (sum_blue),
        .launch_flags (launch_flags),
        .busy         (div_busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .avg_red      (avg_red),
        .avg_green    (avg_green),
        .avg_blue     (avg_blue),
        .row_end      (row_end),
        .frame_end    (frame_end)
    );

endmodule

### rtl/bxds_checker.sv
// Port-level checks for box_average_downscale, attached by bind.
// Uses bxds_pkg.
module bxds_checker import bxds_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [QUOT_W-1:0] avg_red,
    input logic [QUOT_W-1:0] avg_green,
    input logic [QUOT_W-1:0] avg_blue,
    input logic              row_end,
    input logic              frame_end
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(avg_red) && $stable(avg_green)
            && $stable(avg_blue) && $stable(row_end) && $stable(frame_end))
        else $error("stalled result changed");

    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> row_end)
        else $error("frame end without row end");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result shown during reset");

endmodule

bind box_average_downscale bxds_checker u_bxds_checker (.*);
